// File: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PAT_MAX = 32;
  localparam int IDX_W   = $clog2(PAT_MAX);
  localparam int LEN_W   = IDX_W + 1;
  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_SCAN  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_NUMBER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] entry_index;
    logic [8:0] entry_value;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_t;

  // Broadcast controls for the cell row.
  typedef struct packed {
    logic scan;
    logic clear;
    logic rotate;
  } cell_ctrl_t;

endpackage

// File: rtl/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// A result is pushed into the registered output buffer when its byte is taken.
// Throughput: one transaction per cycle while the output buffer has room; the
// cell row compares the whole window in the cycle a byte enters. After a
// pattern_length write the pattern ring rotates into place, one step a cycle,
// with in_ready low. Reset clears control state; the block is idle until begun.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wbps_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wbps_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]         cfg_data
);
  import wbps_pkg::*;

  logic [LEN_W-1:0]  pattern_length;
  logic [CNT_W-1:0]  match_number;
  logic [ADDR_W-1:0] base_address;

  logic [CNT_W-1:0]  bytes_seen, matches_seen;
  logic              search_done;
  logic [LEN_W-1:0]  fill;
  logic [IDX_W-1:0]  rot;

  logic [LEN_W-1:0]  len_eff, fill_next;
  logic [IDX_W-1:0]  rot_target, load_sel;
  logic              aligned, accept, scan_go, all_hit, match, found, push, buf_full;
  logic [CNT_W-1:0]  bytes_next, matches_next;
  logic [ADDR_W-1:0] match_addr;
  cell_ctrl_t        ctrl;
  out_t              push_data;

  logic [7:0]         win_q  [PAT_MAX];
  logic [8:0]         pat_q  [PAT_MAX];
  logic [PAT_MAX-1:0] hit, active, load;

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(PAT_MAX)) begin
      len_eff = LEN_W'(PAT_MAX);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Cell i holds pattern entry (rot - i) mod PAT_MAX; aligned when rot = len-1.
  assign rot_target = IDX_W'(len_eff - LEN_W'(1));
  assign aligned    = (rot == rot_target);
  assign in_ready   = aligned && !buf_full;
  assign accept     = in_valid && in_ready;
  assign load_sel   = rot - in_data.entry_index;

  assign scan_go = accept && (in_data.action == ACT_SCAN) && !search_done;

  assign ctrl.scan   = scan_go;
  assign ctrl.clear  = accept && (in_data.action == ACT_BEGIN);
  assign ctrl.rotate = !aligned;

  genvar i;
  generate
    for (i = 0; i < PAT_MAX; i++) begin : g_cell
      localparam int PREV = (i + PAT_MAX - 1) % PAT_MAX;
      logic [7:0] win_in;
      if (i == 0) begin : g_head
        assign win_in = in_data.data_byte;
      end else begin : g_body
        assign win_in = win_q[i-1];
      end
      assign active[i] = (LEN_W'(i) < len_eff);
      assign load[i]   = accept && (in_data.action == ACT_LOAD) &&
                         (load_sel == IDX_W'(i));
      wbps_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .active     (active[i]),
        .win_in     (win_in),
        .pat_in     (pat_q[PREV]),
        .load       (load[i]),
        .load_value (in_data.entry_value),
        .win_q      (win_q[i]),
        .pat_q      (pat_q[i]),
        .hit        (hit[i])
      );
    end
  endgenerate

  assign all_hit      = &hit;
  assign fill_next    = (fill == LEN_W'(PAT_MAX)) ? fill : fill + LEN_W'(1);
  assign bytes_next   = bytes_seen + CNT_W'(1);
  assign matches_next = matches_seen + CNT_W'(1);
  assign match        = scan_go && all_hit && (fill_next >= len_eff);
  assign found        = match && (matches_next == match_number);
  assign match_addr   = base_address + bytes_next - ADDR_W'(len_eff);
  assign push         = found || (scan_go && in_data.last_byte);

  assign push_data.found         = found;
  assign push_data.match_address = found ? match_addr : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      match_number   <= CNT_W'(1);
      base_address   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_MATCH_NUMBER:   match_number   <= cfg_data[CNT_W-1:0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      matches_seen <= '0;
      search_done  <= 1'b1;
      fill         <= '0;
      rot          <= '0;
    end else begin
      // Advance the pattern ring one step toward alignment.
      if (!aligned) begin
        rot <= rot + IDX_W'(1);
      end
      if (ctrl.clear) begin
        bytes_seen   <= '0;
        matches_seen <= '0;
        fill         <= '0;
        search_done  <= 1'b0;
      end else if (scan_go) begin
        bytes_seen <= bytes_next;
        fill       <= fill_next;
        if (match) begin
          matches_seen <= matches_next;
        end
        if (push) begin
          search_done <= 1'b1;
        end
      end
    end
  end

  wbps_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One window position: holds a scanned byte and a pattern entry, passes both
// to the next cell and reports whether its byte satisfies its entry.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic               clk,
  input  logic               rst,
  input  wbps_pkg::cell_ctrl_t ctrl,
  input  logic               active,
  input  logic [7:0]         win_in,
  input  logic [8:0]         pat_in,
  input  logic               load,
  input  logic [8:0]         load_value,
  output logic [7:0]         win_q,
  output logic [8:0]         pat_q,
  output logic               hit
);
  import wbps_pkg::*;

  logic [7:0] win;
  logic [8:0] pat;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctrl.clear) begin
      win <= '0;
    end else if (ctrl.scan) begin
      win <= win_in;
    end
  end

  // Pattern ring: rotate one place or take a load, never both.
  always_ff @(posedge clk) begin
    if (load) begin
      pat <= load_value;
    end else if (ctrl.rotate) begin
      pat <= pat_in;
    end
  end

  // Compare against the byte that lands here on this scan.
  assign hit   = !active || pat[8] || (pat[7:0] == win_in);
  assign win_q = win;
  assign pat_q = pat;

endmodule

// File: rtl/wbps_outbuf.sv
// ----------------------------------------------------------------------------
// wbps_outbuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module wbps_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wbps_pkg::out_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output wbps_pkg::out_t out_data
);
  import wbps_pkg::*;

  logic head_v, skid_v, head_v_next, skid_v_next, pop;
  out_t head, skid, head_next, skid_next;

  assign pop = head_v && out_ready;

  always_comb begin
    head_v_next = head_v && !pop;
    skid_v_next = skid_v;
    head_next   = head;
    skid_next   = skid;
    if (pop && skid_v) begin
      head_next   = skid;
      head_v_next = 1'b1;
      skid_v_next = 1'b0;
    end
    if (push) begin
      if (!head_v_next) begin
        head_next   = push_data;
        head_v_next = 1'b1;
      end else begin
        skid_next   = push_data;
        skid_v_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      head_v <= head_v_next;
      skid_v <= skid_v_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    skid <= skid_next;
  end

  assign full      = skid_v;
  assign out_valid = head_v;
  assign out_data  = head;

endmodule
